FILE: hdl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, constants and the reciprocal factorial table of the
// bisection root finder.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int MAX_STEPS_DEF  = 64;
  localparam int SINE_TERMS_DEF = 6;
  localparam int FRAC_BITS_DEF  = 24;

  localparam logic [30:0] TOL_RESET = 31'd16777;

  typedef struct packed {
    logic signed [31:0] low_end;
    logic signed [31:0] high_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic               exact_zero;
    logic               step_limit_hit;
    logic [6:0]         steps_used;
  } out_item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_CUBE, F_SQUARE, F_POWER, F_TERM, F_DONE
  } func_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_FA, T_MID, T_WAIT, T_DEC
  } top_state_t;

  // 1/k! for k = 1,3,...,11, unsigned Q1.30; higher indices give zero
  function automatic logic [30:0] recip_q30(input logic [2:0] idx);
    logic [30:0] v;
    case (idx)
      3'd0:    v = 31'd1073741824;
      3'd1:    v = 31'd178956971;
      3'd2:    v = 31'd8947849;
      3'd3:    v = 31'd213044;
      3'd4:    v = 31'd2959;
      3'd5:    v = 31'd27;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/bisection_root_finder.sv
// ----------------------------------------------------------------------------
// bisection_root_finder
// Bisects [low_end, high_end] toward a root of x^3 - 4*sin(x^2), Q8.24.
// ----------------------------------------------------------------------------
// Sequence: f(low_end) once, then per step f(mid) and the relative width in
//   parallel (f on the shared multiplier, the width on the divider), then a decision.
// Up to MAX_STEPS steps.
// Throughput: one item at a time; busy stays high until the result strobe.
// The result sits on out_data for the single cycle out_valid is high.
// Reset: synchronous active low; tolerance returns to 16777, control idles.
// ----------------------------------------------------------------------------
module bisection_root_finder #(
  parameter int MAX_STEPS  = brf_pkg::MAX_STEPS_DEF,
  parameter int SINE_TERMS = brf_pkg::SINE_TERMS_DEF,
  parameter int FRAC_BITS  = brf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  brf_pkg::in_item_t in_data,
  output logic              out_valid,
  output brf_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [30:0]       cfg_data
);

  import brf_pkg::*;

  localparam logic [31:0] ONE_U = 32'(64'd1 << FRAC_BITS);

  top_state_t         state_r, state_nxt;
  logic [30:0]        tol_r, tol_nxt;
  logic signed [31:0] a_r, a_nxt, b_r, b_nxt, mid_r, mid_nxt;
  logic signed [31:0] fa_r, fa_nxt, fm_r, fm_nxt;
  logic [30:0]        err_r, err_nxt;
  logic [6:0]         steps_r, steps_nxt;
  logic               gotf_r, gotf_nxt, gotd_r, gotd_nxt;
  logic               ov_r, ov_nxt;
  out_item_t          od_r, od_nxt;

  logic               f_start, f_done, d_start, d_done;
  logic signed [31:0] f_x, f_val, mid_c;
  logic signed [32:0] sum_ab, dif_s;
  logic [32:0]        dif_u;
  logic [31:0]        mag_u, mag_c;
  logic [30:0]        d_quo;
  logic               flip;

  brf_func #(.SINE_TERMS(SINE_TERMS), .FRAC_BITS(FRAC_BITS)) u_func (
    .clk(clk), .rst_n(rst_n), .start(f_start), .x(f_x), .done(f_done), .fx(f_val)
  );

  brf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .dif(dif_u), .mag(mag_c),
    .done(d_done), .quo(d_quo)
  );

  // floor midpoint and width operands
  assign sum_ab = 33'(a_r) + 33'(b_r);
  assign mid_c  = sum_ab[32:1];
  assign dif_s  = 33'(b_r) - 33'(a_r);
  assign dif_u  = dif_s[32] ? 33'(-dif_s) : 33'(dif_s);
  assign mag_u  = b_r[31] ? 32'(-33'(b_r)) : 32'(b_r);
  assign mag_c  = (mag_u < ONE_U) ? ONE_U : mag_u;
  assign flip   = (fa_r[31] && !fm_r[31] && fm_r != '0) ||
                  (!fa_r[31] && fa_r != '0 && fm_r[31]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      tol_r   <= TOL_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tol_r   <= tol_nxt;
      ov_r    <= ov_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    mid_r   <= mid_nxt;
    fa_r    <= fa_nxt;
    fm_r    <= fm_nxt;
    err_r   <= err_nxt;
    steps_r <= steps_nxt;
    gotf_r  <= gotf_nxt;
    gotd_r  <= gotd_nxt;
    od_r    <= od_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    tol_nxt   = (cfg_valid && cfg_ready) ? cfg_data : tol_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    mid_nxt   = mid_r;
    fa_nxt    = fa_r;
    fm_nxt    = fm_r;
    err_nxt   = err_r;
    steps_nxt = steps_r;
    gotf_nxt  = gotf_r;
    gotd_nxt  = gotd_r;
    ov_nxt    = 1'b0;
    od_nxt    = od_r;
    f_start   = 1'b0;
    d_start   = 1'b0;
    f_x       = (state_r == T_IDLE) ? in_data.low_end : mid_c;
    case (state_r)
      T_IDLE: begin
        if (start) begin
          a_nxt     = in_data.low_end;
          b_nxt     = in_data.high_end;
          steps_nxt = '0;
          f_start   = 1'b1;
          state_nxt = T_FA;
        end
      end
      T_FA: begin
        // f(low) once; afterwards it tracks f(mid) when low moves
        if (f_done) begin
          fa_nxt    = f_val;
          state_nxt = T_MID;
        end
      end
      T_MID: begin
        f_start   = 1'b1;
        d_start   = 1'b1;
        mid_nxt   = mid_c;
        steps_nxt = steps_r + 1'b1;
        gotf_nxt  = 1'b0;
        gotd_nxt  = 1'b0;
        state_nxt = T_WAIT;
      end
      T_WAIT: begin
        if (f_done) begin
          fm_nxt   = f_val;
          gotf_nxt = 1'b1;
        end
        if (d_done) begin
          err_nxt  = d_quo;
          gotd_nxt = 1'b1;
        end
        if (gotf_nxt && gotd_nxt) begin
          state_nxt = T_DEC;
        end
      end
      T_DEC: begin
        od_nxt.root           = mid_r;
        od_nxt.steps_used     = steps_r;
        od_nxt.exact_zero     = 1'b0;
        od_nxt.step_limit_hit = 1'b0;
        if (fm_r == '0) begin
          od_nxt.exact_zero = 1'b1;
          ov_nxt            = 1'b1;
          state_nxt         = T_IDLE;
        end else if (err_r < tol_r) begin
          ov_nxt    = 1'b1;
          state_nxt = T_IDLE;
        end else begin
          if (flip) begin
            b_nxt = mid_r;
          end else begin
            a_nxt  = mid_r;
            fa_nxt = fm_r;
          end
          if (err_r == tol_r) begin
            ov_nxt    = 1'b1;
            state_nxt = T_IDLE;
          end else if (steps_r >= 7'(MAX_STEPS)) begin
            od_nxt.step_limit_hit = 1'b1;
            ov_nxt                = 1'b1;
            state_nxt             = T_IDLE;
          end else begin
            state_nxt = T_MID;
          end
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  assign busy      = (state_r != T_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.steps_used != '0 && out_data.steps_used <= 7'(MAX_STEPS)))
    else $error("steps_used out of range");

  a_cap_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.step_limit_hit) |-> out_data.steps_used == 7'(MAX_STEPS))
    else $error("step cap flagged below the cap");

endmodule

FILE: hdl/brf_mul.sv
// ----------------------------------------------------------------------------
// brf_mul
// Shared 33x33 signed multiplier with registered product.
// ----------------------------------------------------------------------------
module brf_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 66'(a) * 66'(b);
  end

  assign prod = prod_r;

endmodule

FILE: hdl/brf_div.sv
// ----------------------------------------------------------------------------
// brf_div
// Bit-serial restoring divider for the relative width, saturated to 31 bits.
// ----------------------------------------------------------------------------
module brf_div #(
  parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dif,
  input  logic [31:0] mag,
  output logic        done,
  output logic [30:0] quo
);

  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dq_r, dq_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   sh;
  logic          qbit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    sh       = {rem_r[31:0], dq_r[DW-1]};
    qbit     = (sh >= {1'b0, d_r});
    if (start) begin
      dq_nxt  = {dif, {FRAC_BITS{1'b0}}};
      rem_nxt = '0;
      d_nxt   = mag;
      cnt_nxt = CW'(DW);
    end else if (cnt_r != '0) begin
      rem_nxt = qbit ? sh - {1'b0, d_r} : sh;
      dq_nxt  = {dq_r[DW-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = (|dq_r[DW-1:31]) ? 31'h7FFFFFFF : dq_r[30:0];

endmodule

FILE: hdl/brf_func.sv
// ----------------------------------------------------------------------------
// brf_func
// Sequencer for f(x) = x^3 - 4*sin(x^2) on the shared multiplier.
// ----------------------------------------------------------------------------
module brf_func #(
  parameter int SINE_TERMS = brf_pkg::SINE_TERMS_DEF,
  parameter int FRAC_BITS  = brf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] x,
  output logic               done,
  output logic signed [31:0] fx
);

  import brf_pkg::*;

  localparam int IW = (SINE_TERMS > 1) ? $clog2(SINE_TERMS) : 1;
  localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  func_state_t        state_r, state_nxt;
  logic               ph_r, ph_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic signed [31:0] x_r, x_nxt, r_r, r_nxt, arc_r, arc_nxt;
  logic signed [31:0] cube_r, cube_nxt, sum_r, sum_nxt, fx_r, fx_nxt;
  logic               done_r, done_nxt;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, term;
  logic signed [31:0] mul_res, s4;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  brf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  assign mul_res = sat32(prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      ph_r    <= ph_nxt;
    end
    cnt_r  <= cnt_nxt;
    i_r    <= i_nxt;
    x_r    <= x_nxt;
    r_r    <= r_nxt;
    arc_r  <= arc_nxt;
    cube_r <= cube_nxt;
    sum_r  <= sum_nxt;
    fx_r   <= fx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    x_nxt     = x_r;
    r_nxt     = r_r;
    arc_nxt   = arc_r;
    cube_nxt  = cube_r;
    sum_nxt   = sum_r;
    fx_nxt    = fx_r;
    done_nxt  = 1'b0;
    mul_a     = 33'(r_r);
    mul_b     = (state_r == F_POWER) ? 33'(arc_r) : 33'(x_r);
    term      = prod >>> 30;
    s4        = sat32(66'(sum_r) <<< 2);
    if (state_r == F_TERM) begin
      mul_b = {2'b00, recip_q30(3'(i_r))};
    end
    case (state_r)
      F_IDLE: begin
        if (start) begin
          x_nxt     = x;
          r_nxt     = ONE;
          cnt_nxt   = '0;
          ph_nxt    = 1'b0;
          state_nxt = F_CUBE;
        end
      end
      F_CUBE: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          r_nxt   = mul_res;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 2'd2) begin
            cube_nxt  = mul_res;
            r_nxt     = ONE;
            cnt_nxt   = '0;
            state_nxt = F_SQUARE;
          end
        end
      end
      F_SQUARE: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          r_nxt   = mul_res;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 2'd1) begin
            arc_nxt   = mul_res;
            r_nxt     = ONE;
            cnt_nxt   = '0;
            i_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = F_POWER;
          end
        end
      end
      F_POWER: begin
        // first term needs arc^1, later ones two more factors of arc
        ph_nxt = !ph_r;
        if (ph_r) begin
          r_nxt   = mul_res;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == ((i_r == '0) ? 2'd0 : 2'd1)) begin
            cnt_nxt   = '0;
            state_nxt = F_TERM;
          end
        end
      end
      F_TERM: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          sum_nxt = i_r[0] ? sat32(66'(sum_r) - term) : sat32(66'(sum_r) + term);
          if (i_r == IW'(SINE_TERMS - 1)) begin
            state_nxt = F_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = F_POWER;
          end
        end
      end
      F_DONE: begin
        fx_nxt    = sat32(66'(cube_r) - 66'(s4));
        done_nxt  = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign done = done_r;
  assign fx   = fx_r;

endmodule
